/* sv/led_flash_timer_defines.svh */
// Assertion helpers for the LED flash timer checker.
// Each macro uses the checker's i_clk and i_rst_n.
`ifndef LED_FLASH_TIMER_DEFINES_SVH
`define LED_FLASH_TIMER_DEFINES_SVH

// Same-cycle implication, checking is disabled while in reset.
`define LFT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checking is disabled while in reset.
`define LFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lft_pkg.sv */
package lft_pkg;

    localparam int CHANNELS = 4;     // 1 to 16
    localparam int TICK_MS  = 100;   // 1 to 1000

    localparam int MS_W    = 16;
    localparam int CNT_W   = 10;
    localparam int OP_W    = 2;
    localparam int SEL_W   = 2;
    localparam int LED_W   = 4;      // levels reported for channels 0 to 3

    localparam int IN_TDATA_W  = 2 * MS_W;
    localparam int IN_TUSER_W  = OP_W + SEL_W;
    localparam int OUT_TDATA_W = ((LED_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Reciprocal for exact floor(ms / TICK_MS) over all MS_W-bit values:
    // m = ceil(2^(N+l) / d), l = ceil(log2 d), quotient = (x * m) >> (N+l).
    localparam int RECIP_SHIFT = MS_W + $clog2(TICK_MS);
    localparam longint unsigned RECIP_MUL_L =
        ((64'd1 << RECIP_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam int RECIP_W = MS_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_MUL_L);
    localparam int PROD_W = MS_W + RECIP_W;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_ON       = 2'd1,
        OP_OFF      = 2'd2,
        OP_ACTIVATE = 2'd3
    } t_opcode;

    // Per-channel command; start and clear are qualified by channel select, tick goes to every channel
    typedef struct packed {
        logic             tick;
        logic             start;
        logic             clear;
        logic [CNT_W-1:0] interval;
        logic [CNT_W-1:0] duration;
    } t_chan_cmd;

    // Milliseconds to ticks, floor division, saturating at CNT_MAX
    function automatic logic [CNT_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        logic [PROD_W-1:0] prod;
        logic [MS_W-1:0]   quo;
        prod = PROD_W'(ms) * PROD_W'(RECIP_MUL);
        quo  = MS_W'(prod >> RECIP_SHIFT);
        if (quo > MS_W'(CNT_MAX)) begin
            return CNT_MAX;
        end
        return quo[CNT_W-1:0];
    endfunction

endpackage

/* sv/lft_channel.sv */
module lft_channel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lft_pkg::t_chan_cmd    i_cmd,
    output logic                  o_level_n   // level after this command
);

    logic [lft_pkg::CNT_W-1:0] r_ivl, n_ivl;
    logic [lft_pkg::CNT_W-1:0] r_dur, n_dur;
    logic [lft_pkg::CNT_W-1:0] r_elapsed, n_elapsed;
    logic [lft_pkg::CNT_W-1:0] r_phase, n_phase;
    logic                      r_active, n_active;
    logic                      r_level, n_level;
    logic [lft_pkg::CNT_W:0]   phase_inc;

    assign phase_inc = {1'b0, r_phase} + (lft_pkg::CNT_W+1)'(1);

    always_comb begin
        n_ivl     = r_ivl;
        n_dur     = r_dur;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        n_active  = r_active;
        n_level   = r_level;
        if (i_cmd.clear) begin
            n_ivl     = '0;
            n_dur     = '0;
            n_elapsed = '0;
            n_phase   = '0;
            n_active  = 1'b0;
            n_level   = 1'b0;
        end else if (i_cmd.start) begin
            n_ivl     = i_cmd.interval;
            n_dur     = i_cmd.duration;
            n_elapsed = '0;
            n_phase   = '0;
            n_active  = 1'b1;
            n_level   = 1'b1;
        end else if (i_cmd.tick && r_active) begin
            if (r_elapsed != lft_pkg::CNT_MAX) begin
                n_elapsed = r_elapsed + lft_pkg::CNT_W'(1);
            end
            if (r_ivl != '0) begin
                if (phase_inc >= {1'b0, r_ivl}) begin
                    n_phase = '0;
                    n_level = ~r_level;
                end else begin
                    n_phase = phase_inc[lft_pkg::CNT_W-1:0];
                end
            end
            // timeout: phase and elapsed keep their values
            if (r_dur != '0 && n_elapsed >= r_dur) begin
                n_ivl    = '0;
                n_dur    = '0;
                n_active = 1'b0;
                n_level  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivl     <= '0;
            r_dur     <= '0;
            r_elapsed <= '0;
            r_phase   <= '0;
            r_active  <= 1'b0;
            r_level   <= 1'b0;
        end else begin
            r_ivl     <= n_ivl;
            r_dur     <= n_dur;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_active  <= n_active;
            r_level   <= n_level;
        end
    end

    assign o_level_n = n_level;

endmodule

/* sv/led_flash_timer.sv */
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: interval_ms, duration_ms
//                                               tuser: opcode, led_select
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: led_levels, zero padded
//
// One command per cycle sustained while m_axis is not stalled; each command yields
// one result transaction, passing through the input register and then the result
// register. The ms-to-tick multiply sits before the input register.
// Synchronous active-low reset clears all channels and both valid flags.
// A stall on m_axis holds the result; the input register still takes a
// command while it is empty, then s_axis_tready drops until the result goes.
module led_flash_timer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] interval_ms, [31:16] duration_ms
    input  logic [lft_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] opcode, [3:2] led_select
    input  logic [lft_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] led_levels, [7:4] zero
    output logic [lft_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // Input register: command already converted to ticks
    logic                          r_in_valid;
    lft_pkg::t_opcode              r_op;
    logic [lft_pkg::SEL_W-1:0]     r_sel;
    logic [lft_pkg::CNT_W-1:0]     r_ivl;
    logic [lft_pkg::CNT_W-1:0]     r_dur;

    // Result register
    logic                          r_out_valid;
    logic [lft_pkg::LED_W-1:0]     r_levels, n_levels;

    logic                          advance;    // result register may load
    logic                          in_accept;
    logic                          process;    // command applied to channels
    logic [lft_pkg::CHANNELS-1:0]  level_n;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign process       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // tick conversion done on the way in, so the channel path stays short
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= lft_pkg::t_opcode'(s_axis_tuser[lft_pkg::OP_W-1:0]);
            r_sel <= s_axis_tuser[lft_pkg::OP_W +: lft_pkg::SEL_W];
            r_ivl <= lft_pkg::ms_to_ticks(s_axis_tdata[lft_pkg::MS_W-1:0]);
            r_dur <= lft_pkg::ms_to_ticks(s_axis_tdata[lft_pkg::MS_W +: lft_pkg::MS_W]);
        end
    end

    // Channels; a select beyond CHANNELS hits none of them
    for (genvar c = 0; c < lft_pkg::CHANNELS; c++) begin : g_chan
        lft_pkg::t_chan_cmd cmd;
        logic               hit;

        assign hit = (32'(r_sel) == c);

        always_comb begin
            cmd          = '0;
            cmd.interval = r_ivl;
            cmd.duration = r_dur;
            if (process) begin
                case (r_op)
                    lft_pkg::OP_TICK: begin
                        cmd.tick = 1'b1;
                    end
                    lft_pkg::OP_ON: begin
                        cmd.start    = hit;
                        cmd.interval = '0;
                        cmd.duration = '0;
                    end
                    lft_pkg::OP_OFF: begin
                        cmd.clear = hit;
                    end
                    lft_pkg::OP_ACTIVATE: begin
                        cmd.start = hit;
                    end
                    default: begin
                    end
                endcase
            end
        end

        lft_channel u_chan (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .o_level_n (level_n[c])
        );
    end

    // Report channels 0 to 3; missing channels read as dark
    for (genvar i = 0; i < lft_pkg::LED_W; i++) begin : g_lvl
        if (i < lft_pkg::CHANNELS) begin : g_have
            assign n_levels[i] = level_n[i];
        end else begin : g_none
            assign n_levels[i] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_levels <= n_levels;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = lft_pkg::OUT_TDATA_W'(r_levels);

endmodule

/* sv/lft_checker.sv */
`include "led_flash_timer_defines.svh"

module lft_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lft_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // stalled result holds
    `LFT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // nothing waiting downstream, so a command must be taken
    `LFT_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "command refused with no result pending")

    // every accepted command shows a valid result once through the input and result registers
    `LFT_ASSERT_IMP(a_result_follows, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid, "no result after command")

    // padding above the levels stays zero
    `LFT_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[lft_pkg::OUT_TDATA_W-1:lft_pkg::LED_W] == '0, "padding bits set")

endmodule

bind led_flash_timer lft_checker u_lft_checker (.*);
